// ===== rtl/core/ptbl_pkg.sv =====
// Shared types, constants and codes for the per-user token bucket limiter.
`default_nettype none

package ptbl_pkg;

   // Table size and tick rate
   localparam int USERS            = 1024;
   localparam int TICKS_PER_SECOND = 1000;

   // Fixed field widths
   localparam int IDX_W   = 10;
   localparam int TICK_W  = 32;
   localparam int TOKEN_W = 8;

   // Table addressing and clearing sweep
   localparam int ADDR_W = (USERS > 1) ? $clog2(USERS) : 1;
   localparam int CLR_W  = $clog2(USERS + 1);

   // Reciprocal for floor(delta / TICKS_PER_SECOND), exact over 32-bit deltas
   localparam int              RECIP_LOG   = $clog2(TICKS_PER_SECOND);
   localparam int              RECIP_SHIFT = TICK_W + RECIP_LOG;
   localparam logic [63:0]     RECIP_NUM   = 64'd1 << RECIP_SHIFT;
   localparam logic [63:0]     RECIP_FULL  = (RECIP_NUM + 64'(TICKS_PER_SECOND) - 64'd1)
                                             / 64'(TICKS_PER_SECOND);
   localparam int              RECIP_W     = TICK_W + 1;
   localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_FULL[RECIP_W-1:0];
   localparam int              PROD_W      = TICK_W + RECIP_W;
   localparam int              GAIN_W      = TICK_W + TOKEN_W;

   // Register indexes
   localparam logic CSR_CAPACITY = 1'b0;
   localparam logic CSR_REFILL   = 1'b1;

   // Register reset values
   localparam logic [TOKEN_W-1:0] CAPACITY_RESET = 8'd2;
   localparam logic [TOKEN_W-1:0] REFILL_RESET   = 8'd2;

   // One table entry
   typedef struct packed {
      logic                 valid;
      logic [TOKEN_W-1:0]   tokens;
      logic [TICK_W-1:0]    stamp;
   } entry_type;

   // Verdict for one request
   typedef struct packed {
      logic                 allowed;
      logic [TOKEN_W-1:0]   tokens_left;
   } verdict_type;

endpackage

`default_nettype wire

// ===== rtl/core/ptbl_if.sv =====
// Request and response channel interfaces of the token bucket limiter.
`default_nettype none

interface ptbl_req_if;
   logic        valid;
   logic        ready;
   logic [9:0]  user_index;
   logic [31:0] now_ticks;

   modport source (output valid, output user_index, output now_ticks, input ready);
   modport sink   (input valid, input user_index, input now_ticks, output ready);
endinterface

interface ptbl_rsp_if;
   logic       valid;
   logic       ready;
   logic       allowed;
   logic [7:0] tokens_left;

   modport source (output valid, output allowed, output tokens_left, input ready);
   modport sink   (input valid, input allowed, input tokens_left, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ptbl_store.sv =====
// Bucket table memory with its post-reset clearing sweep.
`default_nettype none

module ptbl_store (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rd_en,
   input  wire logic [ptbl_pkg::ADDR_W-1:0]   rd_addr,
   output      ptbl_pkg::entry_type           rd_data,
   input  wire logic                          wr_en,
   input  wire logic [ptbl_pkg::ADDR_W-1:0]   wr_addr,
   input  wire ptbl_pkg::entry_type           wr_data,
   output      logic                          clr_busy
);

   ptbl_pkg::entry_type mem [ptbl_pkg::USERS];

   logic [ptbl_pkg::CLR_W-1:0] clr_cnt_ff;
   logic [ptbl_pkg::CLR_W-1:0] clr_cnt_in;
   ptbl_pkg::entry_type        rd_data_ff;

   logic                        mem_we;
   logic [ptbl_pkg::ADDR_W-1:0] mem_waddr;
   ptbl_pkg::entry_type         mem_wdata;

   assign clr_busy = (clr_cnt_ff != ptbl_pkg::CLR_W'(ptbl_pkg::USERS));

   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      if (clr_busy) begin
         clr_cnt_in = clr_cnt_ff + ptbl_pkg::CLR_W'(1);
      end
   end

   // Sweep zeroes over the table until every entry is marked unseen
   always_comb begin
      if (clr_busy) begin
         mem_we    = 1'b1;
         mem_waddr = ptbl_pkg::ADDR_W'(clr_cnt_ff);
         mem_wdata = '0;
      end else begin
         mem_we    = wr_en;
         mem_waddr = wr_addr;
         mem_wdata = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ptbl_refill.sv =====
// Refill and take datapath: elapsed seconds, token gain, saturation, verdict.
`default_nettype none

module ptbl_refill (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire ptbl_pkg::entry_type               entry,
   input  wire logic [ptbl_pkg::TICK_W-1:0]       now,
   input  wire logic [ptbl_pkg::TOKEN_W-1:0]      capacity,
   input  wire logic [ptbl_pkg::TOKEN_W-1:0]      refill,
   output      logic                              done,
   output      ptbl_pkg::verdict_type             verdict
);

   logic [2:0] stg_ff;
   logic [2:0] stg_in;

   logic                            seen_ff;
   logic [ptbl_pkg::TOKEN_W-1:0]    tokens_ff;
   logic [ptbl_pkg::TICK_W-1:0]     delta_ff;
   logic [ptbl_pkg::PROD_W-1:0]     prod_ff;
   logic [ptbl_pkg::GAIN_W-1:0]     gain_ff;
   ptbl_pkg::verdict_type           verdict_ff;
   logic                            done_ff;

   logic [ptbl_pkg::TICK_W-1:0]     secs;
   logic [ptbl_pkg::GAIN_W:0]       level_sum;
   logic [ptbl_pkg::TOKEN_W-1:0]    level;
   ptbl_pkg::verdict_type           verdict_in;

   assign stg_in = {stg_ff[1:0], start};

   // Whole seconds: multiply by reciprocal, keep the high part
   assign secs = ptbl_pkg::TICK_W'(prod_ff >> ptbl_pkg::RECIP_SHIFT);

   always_comb begin
      level_sum = {1'b0, gain_ff} + (ptbl_pkg::GAIN_W + 1)'(tokens_ff);
      if (!seen_ff) begin
         level = capacity;
      end else if (level_sum > (ptbl_pkg::GAIN_W + 1)'(capacity)) begin
         level = capacity;
      end else begin
         level = level_sum[ptbl_pkg::TOKEN_W-1:0];
      end
      verdict_in.allowed     = (level != '0);
      verdict_in.tokens_left = (level != '0) ? level - ptbl_pkg::TOKEN_W'(1) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         stg_ff  <= stg_in;
         done_ff <= stg_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         seen_ff   <= entry.valid;
         tokens_ff <= entry.tokens;
         delta_ff  <= now - entry.stamp;
      end
      if (stg_ff[0]) begin
         prod_ff <= ptbl_pkg::PROD_W'(delta_ff) * ptbl_pkg::PROD_W'(ptbl_pkg::RECIP_MULT);
      end
      if (stg_ff[1]) begin
         gain_ff <= ptbl_pkg::GAIN_W'(secs) * ptbl_pkg::GAIN_W'(refill);
      end
      if (stg_ff[2]) begin
         verdict_ff <= verdict_in;
      end
   end

   assign done    = done_ff;
   assign verdict = verdict_ff;

endmodule

`default_nettype wire

// ===== rtl/core/per_user_token_bucket_limiter.sv =====
// Top level of the per-user token bucket limiter.
//
// Polices a request stream per user. Each request names a user table entry
// and the current tick time; an unseen entry starts with bucket_capacity
// tokens, a seen one gains refill_per_second tokens for every whole second
// since its last stamp (capped at bucket_capacity), the stamp moves to now,
// and one token is taken if any is held. The response gives the verdict and
// the tokens left (zero when refused). Requests are handled one at a time:
// each passes through the table read, the operand capture, the three-stage
// refill datapath (reciprocal multiply, gain multiply, saturate), the
// write-back with hand-off and the return to idle before the next request
// is accepted. A finished response waits in an output register, so the
// next request is accepted while it is pending. After reset the table is
// swept clear; no request is accepted during the sweep, while configuration
// writes are taken as usual. Write the registers only while the block is
// idle.
`default_nettype none

module per_user_token_bucket_limiter (
   input  wire logic         clock,
   input  wire logic         reset,
   ptbl_req_if.sink          req_bus,
   ptbl_rsp_if.source        rsp_bus,
   input  wire logic         csr_we,
   input  wire logic         csr_index,
   input  wire logic [7:0]   csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_CALC = 2'd2;
   localparam logic [1:0] ST_SEND = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Configuration registers
   logic [ptbl_pkg::TOKEN_W-1:0] capacity_ff;
   logic [ptbl_pkg::TOKEN_W-1:0] refill_ff;

   // Request hold
   logic [ptbl_pkg::ADDR_W-1:0]  addr_ff;
   logic [ptbl_pkg::TICK_W-1:0]  now_ff;
   ptbl_pkg::verdict_type        result_ff;
   ptbl_pkg::verdict_type        result_in;

   // Output register
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   ptbl_pkg::verdict_type        rsp_data_ff;

   logic                         clr_busy;
   logic                         accept;
   logic                         in_range;
   logic                         slot_free;
   ptbl_pkg::entry_type          rd_entry;
   ptbl_pkg::entry_type          wr_entry;
   logic                         calc_done;
   ptbl_pkg::verdict_type        calc_verdict;
   logic                         calc_start;
   logic                         load_rsp;

   assign req_bus.ready = (state_ff == ST_IDLE) && !clr_busy;
   assign accept        = req_bus.valid && req_bus.ready;
   assign in_range      = (int'(req_bus.user_index) < ptbl_pkg::USERS);
   assign calc_start    = (state_ff == ST_READ);
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;
   assign load_rsp      = (state_ff == ST_SEND) && slot_free;

   // Write back the updated entry as soon as the verdict is ready
   assign wr_entry.valid  = 1'b1;
   assign wr_entry.tokens = calc_verdict.tokens_left;
   assign wr_entry.stamp  = now_ff;

   ptbl_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept && in_range),
      .rd_addr  (ptbl_pkg::ADDR_W'(req_bus.user_index)),
      .rd_data  (rd_entry),
      .wr_en    (calc_done),
      .wr_addr  (addr_ff),
      .wr_data  (wr_entry),
      .clr_busy (clr_busy)
   );

   ptbl_refill u_refill (
      .clock    (clock),
      .reset    (reset),
      .start    (calc_start),
      .entry    (rd_entry),
      .now      (now_ff),
      .capacity (capacity_ff),
      .refill   (refill_ff),
      .done     (calc_done),
      .verdict  (calc_verdict)
   );

   // Sequence one request: read, refill, write back, hand off
   always_comb begin
      state_in  = state_ff;
      result_in = result_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (in_range) begin
                  state_in = ST_READ;
               end else begin
                  // Refuse an index past the table and leave the table alone
                  result_in = '0;
                  state_in  = ST_SEND;
               end
            end
         end
         ST_READ: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (calc_done) begin
               result_in = calc_verdict;
               state_in  = ST_SEND;
            end
         end
         ST_SEND: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         capacity_ff  <= ptbl_pkg::CAPACITY_RESET;
         refill_ff    <= ptbl_pkg::REFILL_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               ptbl_pkg::CSR_CAPACITY: capacity_ff <= csr_wdata;
               ptbl_pkg::CSR_REFILL:   refill_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Payload holds, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff <= ptbl_pkg::ADDR_W'(req_bus.user_index);
         now_ff  <= req_bus.now_ticks;
      end
      result_ff <= result_in;
      if (load_rsp) begin
         rsp_data_ff <= result_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.allowed     = rsp_data_ff.allowed;
   assign rsp_bus.tokens_left = rsp_data_ff.tokens_left;

   // No request enters while the table sweep runs
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !accept)
      else $error("request accepted during table clear");

   // Refill results arrive only while waiting for them
   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      calc_done |-> (state_ff == ST_CALC))
      else $error("refill done outside calc state");

   // An accepted request goes to the table read or straight to the hand-off
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      accept |=> ((state_ff == ST_READ) || (state_ff == ST_SEND)))
      else $error("bad state after accept");

   // A refused response reports no tokens
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.allowed) |-> (rsp_data_ff.tokens_left == '0))
      else $error("refused response with tokens left");

   // The table write-back is followed by the hand-off of its verdict
   a_write_on_done: assert property (@(posedge clock) disable iff (reset)
      calc_done |=> (state_ff == ST_SEND))
      else $error("verdict not handed off after write-back");

endmodule

`default_nettype wire

// ===== tb/ptbl_checker.sv =====
// Checker for the token bucket limiter: tracks register writes, predicts each verdict, compares.
module ptbl_checker
   import ptbl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   ptbl_req_if                req_bus,
   ptbl_rsp_if                rsp_bus,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [TOKEN_W-1:0] csr_wdata,
   output int unsigned        fail_count,
   output int unsigned        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [TOKEN_W-1:0] capacity;
   logic [TOKEN_W-1:0] refill;
   logic [TOKEN_W-1:0] held_tokens [USERS];
   logic [TICK_W-1:0]  refill_stamp [USERS];
   logic               entry_seen [USERS];

   verdict_type        expected_verdicts [$];

   // Refill, clamp and consume one token for the named user.
   function automatic verdict_type police_request(input logic [IDX_W-1:0] idx,
                                                  input logic [TICK_W-1:0] now);
      verdict_type       verdict;
      logic [TICK_W-1:0] elapsed;
      logic [63:0]       level;
      verdict = '0;
      if (int'(idx) >= USERS) return verdict;
      if (!entry_seen[idx]) begin
         level = 64'(capacity);
         entry_seen[idx] = 1'b1;
      end else begin
         elapsed = now - refill_stamp[idx];
         level = 64'(held_tokens[idx])
               + (64'(elapsed) / 64'(TICKS_PER_SECOND)) * 64'(refill);
         if (level > 64'(capacity)) level = 64'(capacity);
      end
      refill_stamp[idx] = now;
      if (level != 64'd0) begin
         level = level - 64'd1;
         held_tokens[idx] = level[TOKEN_W-1:0];
         verdict.allowed = 1'b1;
         verdict.tokens_left = level[TOKEN_W-1:0];
      end else begin
         held_tokens[idx] = '0;
      end
      return verdict;
   endfunction

   always @(posedge clock) begin
      verdict_type got;
      verdict_type want;
      if (reset) begin
         capacity = CAPACITY_RESET;
         refill = REFILL_RESET;
         for (int i = 0; i < USERS; i++) entry_seen[i] = 1'b0;
         expected_verdicts.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_CAPACITY) capacity = csr_wdata;
            else refill = csr_wdata;
         end
         // the response of this edge belongs to an older request: compare first
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.allowed = rsp_bus.allowed;
            got.tokens_left = rsp_bus.tokens_left;
            if (expected_verdicts.size() == 0) begin
               $display("%0t: response with no request waiting: allowed %0b tokens_left %0d",
                        $time, got.allowed, got.tokens_left);
               fail_count++;
            end else begin
               want = expected_verdicts.pop_front();
               if (got.allowed !== want.allowed) begin
                  $display("%0t: allowed mismatch: expected %0b actual %0b",
                           $time, want.allowed, got.allowed);
                  fail_count++;
               end
               if (got.tokens_left !== want.tokens_left) begin
                  $display("%0t: tokens_left mismatch: expected %0d actual %0d",
                           $time, want.tokens_left, got.tokens_left);
                  fail_count++;
               end
            end
         end
         // append the prediction at the tail of the queue
         if (req_bus.valid && req_bus.ready)
            expected_verdicts.insert(expected_verdicts.size(),
                                     police_request(req_bus.user_index,
                                                    req_bus.now_ticks));
      end
      pending = expected_verdicts.size();
   end

endmodule

// ===== tb/testbench.sv =====
// Top of the token bucket limiter testbench: clock, reset, stimulus, idling and verdict.
module testbench;
   import ptbl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Slowest run: ~825 requests plus heavy stalls and gaps,
   // after the clearing sweep; this leaves a wide margin.
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned SETTLE_CYCLES = 20;
   localparam int unsigned PHASE_ITEMS   = 200;

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic               csr_index;
   logic [TOKEN_W-1:0] csr_wdata;

   ptbl_req_if req_bus ();
   ptbl_rsp_if rsp_bus ();

   int unsigned        fail_count;
   int unsigned        pending;
   int unsigned        cycle_count = 0;
   int unsigned        request_count;
   int unsigned        send_idle_pct;
   int unsigned        stall_pct;
   logic [TICK_W-1:0]  now;
   logic [IDX_W-1:0]   hot_users [8];

   per_user_token_bucket_limiter dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ptbl_checker verdict_check (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Drive the response ready; stall at the rate of the current phase.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Offer one request, with random idle cycles first; return at the falling
   // edge after acceptance so the next request can follow back to back.
   task automatic send_request(input logic [IDX_W-1:0] idx, input logic [TICK_W-1:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.user_index <= idx;
      req_bus.now_ticks <= t;
      do @(posedge clock); while (!req_bus.ready);
      request_count++;
      @(negedge clock);
   endtask

   // Drop valid, wait for every response, then let the pipeline drain.
   task automatic settle_block();
      req_bus.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write one register; hold the enable for a single edge.
   task automatic write_register(input logic index, input logic [TOKEN_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [TOKEN_W-1:0] cap, input logic [TOKEN_W-1:0] rate);
      write_register(CSR_CAPACITY, cap);
      write_register(CSR_REFILL, rate);
   endtask

   // Mostly repeat traffic from a few hot users with time creeping forward,
   // so buckets drain, refill and saturate; the rest is long gaps, random
   // users and random time jumps.
   task automatic run_random_phase(input int unsigned items);
      int unsigned      pick;
      logic [IDX_W-1:0] idx;
      for (int k = 0; k < 8; k++) hot_users[k] = IDX_W'($urandom_range(USERS - 1));
      repeat (items) begin
         pick = $urandom_range(99);
         idx = hot_users[3'($urandom_range(7))];
         if (pick < 60) begin
            now = now + TICK_W'($urandom_range(400));
         end else if (pick < 80) begin
            now = now + TICK_W'($urandom_range(3 * TICKS_PER_SECOND));
         end else if (pick < 88) begin
            now = now + TICK_W'($urandom_range(300 * TICKS_PER_SECOND));
         end else if (pick < 96) begin
            idx = IDX_W'($urandom());
            now = now + TICK_W'($urandom_range(TICKS_PER_SECOND));
         end else begin
            now = $urandom();
         end
         send_request(idx, now);
      end
   endtask

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_CAPACITY;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.user_index <= '0;
      req_bus.now_ticks <= '0;
      send_idle_pct = 0;
      stall_pct = 0;
      request_count = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed part under reset settings: capacity 2, refill 2.
      // New entry starts full, drain it, then refuse.
      send_request(10'd0, 32'd0);
      send_request(10'd0, 32'd0);
      send_request(10'd0, 32'd0);
      // Under a second twice: the fraction is dropped each time, still refused.
      send_request(10'd0, 32'd999);
      send_request(10'd0, 32'd1998);
      // One whole second: refill to capacity and admit.
      send_request(10'd0, 32'd2998);
      // Tick counter wraps between the two requests of the top user.
      send_request(10'd1023, 32'hFFFF_FF00);
      send_request(10'd1023, 32'h0000_0400);
      send_request(10'h155, 32'hAAAA_AAAA);
      send_request(10'h2AA, 32'h5555_5555);
      send_request(10'h155, 32'hFFFF_FFFF);
      settle_block();

      // Widest settings: fill a bucket to 255 and saturate a huge gain.
      configure(8'd255, 8'd255);
      send_request(10'd5, 32'd100);
      send_request(10'd5, 32'hFFFF_FFFF);
      settle_block();

      // Lower the capacity: the full bucket is clamped down on its next request.
      configure(8'd3, 8'd0);
      send_request(10'd5, 32'hFFFF_FFFF);
      send_request(10'd5, 32'd1000000);
      settle_block();

      // Capacity zero: new and old buckets alike refuse.
      write_register(CSR_CAPACITY, 8'd0);
      send_request(10'd6, 32'd0);
      send_request(10'd5, 32'd5000000);
      send_request(10'd1023, 32'd9000000);
      settle_block();

      // Random part: start close to the wrap so the counter rolls over.
      now = 32'hFFF0_0000;

      configure(8'd255, 8'd255);
      send_idle_pct = 0;
      stall_pct = 0;
      run_random_phase(PHASE_ITEMS);
      settle_block();

      configure(8'd1, 8'd0);
      send_idle_pct = 85;
      stall_pct = 0;
      run_random_phase(PHASE_ITEMS);
      settle_block();

      configure(TOKEN_W'($urandom_range(1, 255)), TOKEN_W'($urandom_range(0, 4)));
      send_idle_pct = 0;
      stall_pct = 85;
      run_random_phase(PHASE_ITEMS);
      settle_block();

      configure(8'd8, 8'd1);
      send_idle_pct = 12;
      stall_pct = 12;
      run_random_phase(PHASE_ITEMS);
      settle_block();

      $display("Ran %0d requests across four idling phases and seven register settings,",
               request_count);
      $display("including clock wrap, dropped fractions, capacity clamp and capacity zero.");
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/ptbl_pkg.sv
rtl/core/ptbl_if.sv
rtl/core/ptbl_store.sv
rtl/core/ptbl_refill.sv
rtl/core/per_user_token_bucket_limiter.sv
tb/ptbl_checker.sv
tb/testbench.sv
